// File: src/rtcm3_pkg.sv
// Shared types, constants and register codes for the RTCM3 frame checker.
`timescale 1ns / 1ps

package rtcm3_pkg;

    // Framing constants
    localparam logic [7:0]  SYNC_BYTE   = 8'hD3;
    localparam logic [23:0] CRC24Q_POLY = 24'h864CFB;  // x^24 term implied

    // Field widths
    localparam int TYPE_W = 12;
    localparam int SUB_W  = 8;
    localparam int LEN_W  = 10;
    localparam int POS_W  = 11;
    localparam int CRC_W  = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_TYPE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_SUB_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_SUB_B = 2'd2;

    localparam logic [TYPE_W-1:0] RST_WANTED_TYPE  = 12'd4090;
    localparam logic [SUB_W-1:0]  RST_WANTED_SUB_A = 8'd7;
    localparam logic [SUB_W-1:0]  RST_WANTED_SUB_B = 8'd8;

    typedef struct packed {
        logic [TYPE_W-1:0] wanted_type;
        logic [SUB_W-1:0]  wanted_sub_a;
        logic [SUB_W-1:0]  wanted_sub_b;
    } t_cfg;

    typedef struct packed {
        logic              crc_ok;
        logic [TYPE_W-1:0] msg_type;
        logic [SUB_W-1:0]  sub_number;
        logic [LEN_W-1:0]  payload_length;
        logic              is_wanted;
    } t_result;

endpackage

// File: src/rtcm3_crc_byte.sv
// CRC-24Q update over one byte, MSB first, unrolled into XOR logic.
`timescale 1ns / 1ps

module rtcm3_crc_byte (
    input  logic [rtcm3_pkg::CRC_W-1:0] i_crc,
    input  logic [7:0]                  i_byte,
    output logic [rtcm3_pkg::CRC_W-1:0] o_crc
);
    import rtcm3_pkg::*;

    // Eight shift/xor steps of the bitwise CRC
    always_comb begin
        logic [CRC_W-1:0] c;
        logic             msb;
        c = i_crc ^ {i_byte, 16'h0000};
        for (int i = 0; i < 8; i++) begin
            msb = c[CRC_W-1];
            c   = {c[CRC_W-2:0], 1'b0};
            if (msb) begin
                c = c ^ CRC24Q_POLY;
            end
        end
        o_crc = c;
    end

endmodule

// File: src/rtcm3_frame_core.sv
// Frame tracking state, CRC accumulation and the result register.
`timescale 1ns / 1ps

module rtcm3_frame_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    input  rtcm3_pkg::t_cfg     i_cfg,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output rtcm3_pkg::t_result  o_result
);
    import rtcm3_pkg::*;

    logic [POS_W-1:0]  r_pos,  n_pos;
    logic [LEN_W-1:0]  r_len,  n_len;
    logic [CRC_W-1:0]  r_crc,  n_crc;
    logic [CRC_W-1:0]  r_rx,   n_rx;
    logic [TYPE_W-1:0] r_type, n_type;
    logic [SUB_W-1:0]  r_sub,  n_sub;
    logic              r_out_valid;
    t_result           r_res,  n_res;
    logic              emit;

    logic [CRC_W-1:0]  crc_in;
    logic [CRC_W-1:0]  crc_upd;
    logic [POS_W-1:0]  len_ext;

    // CRC input is zero at the sync byte
    assign crc_in  = (r_pos == '0) ? '0 : r_crc;
    assign len_ext = {{(POS_W-LEN_W){1'b0}}, r_len};

    rtcm3_crc_byte u_crc (
        .i_crc  (crc_in),
        .i_byte (i_byte),
        .o_crc  (crc_upd)
    );

    // Next frame state and result for the beat at hand
    always_comb begin
        logic ok;
        n_pos  = r_pos;
        n_len  = r_len;
        n_crc  = r_crc;
        n_rx   = r_rx;
        n_type = r_type;
        n_sub  = r_sub;
        emit   = 1'b0;
        ok     = 1'b0;
        if (r_pos == '0) begin
            // hunting: only the sync byte opens a frame
            if (i_byte == SYNC_BYTE) begin
                n_crc  = crc_upd;
                n_rx   = '0;
                n_type = '0;
                n_sub  = '0;
                n_len  = '0;
                n_pos  = POS_W'(1);
            end
        end else begin
            // length field
            if (r_pos == POS_W'(1)) begin
                n_len = {i_byte[1:0], 8'h00};
            end else if (r_pos == POS_W'(2)) begin
                n_len = {r_len[LEN_W-1:8], i_byte};
            end
            // type and sub number capture
            if (r_pos == POS_W'(3)) begin
                n_type = {i_byte, 4'h0};
            end else if (r_pos == POS_W'(4)) begin
                n_type = {r_type[TYPE_W-1:4], i_byte[7:4]};
            end else if (r_pos == POS_W'(5)) begin
                n_sub = i_byte;
            end
            // trailing bytes are the received CRC, the rest feed the CRC
            if (r_pos >= POS_W'(3) && r_pos >= len_ext + POS_W'(3)) begin
                n_rx = {r_rx[CRC_W-9:0], i_byte};
            end else begin
                n_crc = crc_upd;
            end
            // end of frame
            if (r_pos < POS_W'(3) || r_pos < len_ext + POS_W'(5)) begin
                n_pos = r_pos + POS_W'(1);
            end else begin
                emit  = 1'b1;
                n_pos = '0;
            end
        end
        ok = (n_crc == n_rx);
        n_res.crc_ok         = ok;
        n_res.msg_type       = n_type;
        n_res.sub_number     = n_sub;
        n_res.payload_length = n_len;
        n_res.is_wanted      = ok && (n_type == i_cfg.wanted_type) &&
                               ((n_sub == i_cfg.wanted_sub_a) ||
                                (n_sub == i_cfg.wanted_sub_b));
    end

    // Frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_len  <= '0;
            r_crc  <= '0;
            r_rx   <= '0;
            r_type <= '0;
            r_sub  <= '0;
        end else if (i_step) begin
            r_pos  <= n_pos;
            r_len  <= n_len;
            r_crc  <= n_crc;
            r_rx   <= n_rx;
            r_type <= n_type;
            r_sub  <= n_sub;
        end
    end

    // Result register: loaded on the last frame byte, cleared when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_step && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && emit) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_res;

    // Position never runs past the frame end
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < POS_W'(3) || r_pos <= len_ext + POS_W'(5))
        else $error("frame position beyond frame end");

    // After the last byte the checker hunts again
    a_emit_resync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && emit) |=> (r_pos == '0))
        else $error("no return to sync search after frame");

    // A wanted frame always passed its CRC
    a_wanted_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.is_wanted) |-> r_res.crc_ok)
        else $error("wanted flag without CRC pass");

    // A new result only follows a processed byte
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_step))
        else $error("result appeared without a processed beat");

endmodule

// File: src/rtcm3_frame_checker.sv
// Top level of the RTCM3 frame checker: input stage, registers, frame core.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_data_byte
//  out     | output    | o_out_valid/i_out_stall | o_crc_ok, o_msg_type, o_sub_number,
//          |           |                         | o_payload_length, o_is_wanted
//  cfg     | input     | i_cfg_we                | i_cfg_index, i_cfg_data
//
// One byte per cycle sustained while the result is not stalled. A byte is
// held in the input register and is folded into the frame state (CRC-24Q
// unrolled over 8 bits) as it moves on; the result of a frame is loaded
// into the output register as the last frame byte moves on. Synchronous
// active-low reset returns to sync search and loads the register defaults.
// A stalled result holds the input register; the input side stalls only then.
`timescale 1ns / 1ps

module rtcm3_frame_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [7:0]                         i_data_byte,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_crc_ok,
    output logic [rtcm3_pkg::TYPE_W-1:0]       o_msg_type,
    output logic [rtcm3_pkg::SUB_W-1:0]        o_sub_number,
    output logic [rtcm3_pkg::LEN_W-1:0]        o_payload_length,
    output logic                               o_is_wanted,
    input  logic                               i_cfg_we,
    input  logic [rtcm3_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rtcm3_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import rtcm3_pkg::*;

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       advance;
    logic       step;
    t_result    result;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wanted_type  <= RST_WANTED_TYPE;
            r_cfg.wanted_sub_a <= RST_WANTED_SUB_A;
            r_cfg.wanted_sub_b <= RST_WANTED_SUB_B;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WANTED_TYPE:  r_cfg.wanted_type  <= i_cfg_data[TYPE_W-1:0];
                CFG_WANTED_SUB_A: r_cfg.wanted_sub_a <= i_cfg_data[SUB_W-1:0];
                CFG_WANTED_SUB_B: r_cfg.wanted_sub_b <= i_cfg_data[SUB_W-1:0];
                default: ;
            endcase
        end
    end

    // Byte moves on when the result register is free or being drained
    assign advance    = !o_out_valid || !i_out_stall;
    assign step       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_byte <= i_data_byte;
        end
    end

    rtcm3_frame_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_cfg       (r_cfg),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_crc_ok         = result.crc_ok;
    assign o_msg_type       = result.msg_type;
    assign o_sub_number     = result.sub_number;
    assign o_payload_length = result.payload_length;
    assign o_is_wanted      = result.is_wanted;

endmodule
